>>> rtl/rbvs_pkg.sv
// ----------------------------------------------------------------------------
// rbvs_pkg
// Shared constants, phase codes and lane control type for the rigid body
// Verlet step block.
// ----------------------------------------------------------------------------
package rbvs_pkg;

	localparam int DT_BITS   = 25;
	localparam logic [DT_BITS-1:0] DT_RESET = 25'd167772;
	localparam int NUM_LANES = 4;
	localparam int PH_BITS   = 3;

	// sequencer phases, one shared lane pass each
	localparam logic [PH_BITS-1:0] PH_INNER = 3'd0;
	localparam logic [PH_BITS-1:0] PH_DQ0   = 3'd1;
	localparam logic [PH_BITS-1:0] PH_DQ1   = 3'd2;
	localparam logic [PH_BITS-1:0] PH_DQ2   = 3'd3;
	localparam logic [PH_BITS-1:0] PH_POS   = 3'd4;
	localparam logic [PH_BITS-1:0] PH_VEL   = 3'd5;
	localparam logic [PH_BITS-1:0] PH_QUAT  = 3'd6;
	localparam logic [PH_BITS-1:0] PH_OMEGA = 3'd7;

	// quaternion derivative: for lane (dq component) and term (omega axis),
	// which q component is multiplied and whether the term is subtracted
	localparam logic [1:0] QSEL [NUM_LANES][3] = '{
		'{2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd3, 2'd2},
		'{2'd3, 2'd0, 2'd1},
		'{2'd2, 2'd1, 2'd0}
	};
	localparam logic QNEG [NUM_LANES][3] = '{
		'{1'b1, 1'b1, 1'b1},
		'{1'b0, 1'b0, 1'b1},
		'{1'b1, 1'b0, 1'b0},
		'{1'b0, 1'b1, 1'b0}
	};

	// lane control captured with the product
	typedef struct packed {
		logic half;   // scale by 2^(F+1) instead of 2^F
		logic neg;    // subtract the rounded product
		logic first;  // start of a sum: no accumulate, no clamp
	} lane_ctl_t;

endpackage

>>> rtl/rbvs_lane.sv
// ----------------------------------------------------------------------------
// rbvs_lane
// One arithmetic lane: registered signed multiply, then round half away from
// zero at F or F+1 fraction bits, saturate, and saturating accumulate.
// ----------------------------------------------------------------------------
module rbvs_lane import rbvs_pkg::*; #(
	parameter int W  = 32,
	parameter int F  = 24,
	parameter int OW = 32
) (
	input  logic                clk,
	input  logic                load,
	input  logic signed [OW-1:0] a,
	input  logic signed [OW-1:0] b,
	input  lane_ctl_t           ctl,
	input  logic signed [W:0]   c,
	output logic signed [W:0]   res
);

	localparam int PW = 2 * OW;
	localparam logic [PW:0] RND0 = (PW+1)'(1) << (F - 1);
	localparam logic [PW:0] RND1 = (PW+1)'(1) << F;
	localparam logic [PW:0] WMAX = (PW+1)'({(W-1){1'b1}});

	logic signed [PW-1:0] prod_s1;
	lane_ctl_t            ctl_s1;

	logic [PW:0]          mag;
	logic [PW:0]          scaled;
	logic                 pneg;
	logic signed [W:0]    m;
	logic signed [W+1:0]  mm;
	logic signed [W+2:0]  sum;

	// product stage
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= a * b;
			ctl_s1  <= ctl;
		end
	end

	// round, saturate, accumulate
	always_comb begin
		pneg   = prod_s1[PW-1];
		mag    = pneg ? (PW+1)'(-$signed({prod_s1[PW-1], prod_s1}))
		              : (PW+1)'({1'b0, prod_s1});
		scaled = ctl_s1.half ? ((mag + RND1) >> (F + 1)) : ((mag + RND0) >> F);
		if (scaled > WMAX + (PW+1)'(pneg))
			m = pneg ? -(W+1)'(WMAX + 1) : (W+1)'(WMAX);
		else
			m = pneg ? -$signed((W+1)'(scaled)) : $signed((W+1)'(scaled));
		mm  = ctl_s1.neg ? -(W+2)'(m) : (W+2)'(m);
		sum = (W+3)'(c) + (W+3)'(mm);
		if (ctl_s1.first)
			res = (W+1)'(mm);
		else if (sum > (W+3)'($signed(WMAX[W:0])))
			res = (W+1)'($signed(WMAX[W:0]));
		else if (sum < -(W+3)'($signed(WMAX[W:0])) - 1)
			res = -(W+1)'($signed(WMAX[W:0])) - 1;
		else
			res = (W+1)'(sum);
	end

endmodule

>>> rtl/rigid_body_verlet_step_top.sv
// ----------------------------------------------------------------------------
// rigid_body_verlet_step_top
// Velocity Verlet step of one rigid particle with quaternion orientation.
// ----------------------------------------------------------------------------
// Each accepted word (new acceleration and torque) is worked in eight
// sequencer phases on four multiply lanes (inner velocity, three quaternion
// derivative terms, position, velocity, quaternion, omega); the result then
// waits in hold until the output register is free to load. The next word is
// taken as soon as the sequencer is back in idle, while a result may still
// wait on the output. time_step may be written any time the block is idle;
// ready is always high.
module rigid_body_verlet_step_top import rbvs_pkg::*; #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         time_step_valid,
	output logic                         time_step_ready,
	input  logic [DT_BITS-1:0]           time_step,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [WORD_WIDTH-1:0] accel_new_x,
	input  logic signed [WORD_WIDTH-1:0] accel_new_y,
	input  logic signed [WORD_WIDTH-1:0] accel_new_z,
	input  logic signed [WORD_WIDTH-1:0] torque_new_x,
	input  logic signed [WORD_WIDTH-1:0] torque_new_y,
	input  logic signed [WORD_WIDTH-1:0] torque_new_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [WORD_WIDTH-1:0] pos_x,
	output logic signed [WORD_WIDTH-1:0] pos_y,
	output logic signed [WORD_WIDTH-1:0] pos_z,
	output logic signed [WORD_WIDTH-1:0] vel_x,
	output logic signed [WORD_WIDTH-1:0] vel_y,
	output logic signed [WORD_WIDTH-1:0] vel_z,
	output logic signed [WORD_WIDTH-1:0] quat_w,
	output logic signed [WORD_WIDTH-1:0] quat_i,
	output logic signed [WORD_WIDTH-1:0] quat_j,
	output logic signed [WORD_WIDTH-1:0] quat_k
);

	localparam int W  = WORD_WIDTH;
	localparam int OW = (W > DT_BITS) ? W : DT_BITS + 1;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE  = W'(1) << FRAC_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	// saturating add of two words
	function automatic logic signed [W-1:0] sat_add(
		input logic signed [W-1:0] x,
		input logic signed [W-1:0] y
	);
		logic signed [W:0] s;
		s = (W+1)'(x) + (W+1)'(y);
		if (s > (W+1)'(WMAX))      sat_add = WMAX;
		else if (s < (W+1)'(WMIN)) sat_add = WMIN;
		else                       sat_add = W'(s);
	endfunction

	logic [1:0]         state_q;
	logic [PH_BITS-1:0] ph_q;
	logic               cyc_q;
	logic [DT_BITS-1:0] dt_q;

	logic signed [W-1:0] pos_q   [3];
	logic signed [W-1:0] vel_q   [3];
	logic signed [W-1:0] pa_q    [3];
	logic signed [W-1:0] om_q    [3];
	logic signed [W-1:0] pt_q    [3];
	logic signed [W-1:0] na_q    [3];
	logic signed [W-1:0] nt_q    [3];
	logic signed [W-1:0] inner_q [3];
	logic signed [W-1:0] quat_q  [NUM_LANES];
	logic signed [W:0]   dq_q    [NUM_LANES];

	logic signed [OW-1:0] op_a [NUM_LANES];
	logic signed [OW-1:0] op_b;
	lane_ctl_t            ctl  [NUM_LANES];
	logic signed [W:0]    acc  [NUM_LANES];
	logic signed [W:0]    res  [NUM_LANES];
	logic                 lane_load;
	logic                 out_valid_q;
	logic signed [W-1:0]  out_q [10];
	logic                 in_acc;
	logic                 out_free;
	logic [1:0]           term;

	assign time_step_ready = 1'b1;
	assign in_stall        = (state_q != ST_IDLE);
	assign in_acc          = in_valid && !in_stall;
	assign lane_load       = (state_q == ST_RUN) && !cyc_q;
	assign out_free        = !out_valid_q || !out_stall;
	assign term            = 2'(ph_q - PH_DQ0);
	assign op_b            = $signed(OW'(dt_q));

	// lane operand and accumulator select per phase
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			op_a[l] = '0;
			ctl[l]  = '{half: 1'b1, neg: 1'b0, first: 1'b0};
			acc[l]  = '0;
			unique case (ph_q)
				PH_INNER: if (l < 3) begin
					op_a[l] = OW'(pa_q[l]);
					acc[l]  = (W+1)'(vel_q[l]);
				end
				PH_DQ0, PH_DQ1, PH_DQ2: begin
					op_a[l] = OW'(quat_q[QSEL[l][term]]);
					ctl[l]  = '{half: 1'b0, neg: QNEG[l][term], first: (ph_q == PH_DQ0)};
					acc[l]  = dq_q[l];
				end
				PH_POS: if (l < 3) begin
					op_a[l]     = OW'(inner_q[l]);
					ctl[l].half = 1'b0;
					acc[l]      = (W+1)'(pos_q[l]);
				end
				PH_VEL: if (l < 3) begin
					op_a[l] = OW'(sat_add(pa_q[l], na_q[l]));
					acc[l]  = (W+1)'(vel_q[l]);
				end
				PH_QUAT: begin
					op_a[l] = OW'($signed(dq_q[l][W-1:0]));
					acc[l]  = (W+1)'(quat_q[l]);
				end
				PH_OMEGA: if (l < 3) begin
					op_a[l] = OW'(sat_add(pt_q[l], nt_q[l]));
					acc[l]  = (W+1)'(om_q[l]);
				end
				default: ;
			endcase
		end
	end

	// omega feeds the quaternion lanes, one axis per term
	logic signed [OW-1:0] op_b_lane [NUM_LANES];
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			if (ph_q == PH_DQ0 || ph_q == PH_DQ1 || ph_q == PH_DQ2)
				op_b_lane[l] = OW'(om_q[term]);
			else
				op_b_lane[l] = op_b;
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		rbvs_lane #(.W(W), .F(FRAC_BITS), .OW(OW)) u_lane (
			.clk  (clk),
			.load (lane_load),
			.a    (op_a[l]),
			.b    (op_b_lane[l]),
			.ctl  (ctl[l]),
			.c    (acc[l]),
			.res  (res[l])
		);
	end

	// sequencer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= PH_INNER;
			cyc_q       <= 1'b0;
			dt_q        <= DT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (time_step_valid && time_step_ready) dt_q <= time_step;
			// output word: load from hold, clear when taken
			if (state_q == ST_HOLD && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					state_q <= ST_RUN;
					ph_q    <= PH_INNER;
					cyc_q   <= 1'b0;
				end
				ST_RUN: begin
					cyc_q <= !cyc_q;
					if (cyc_q) begin
						if (ph_q == PH_OMEGA) state_q <= ST_HOLD;
						else ph_q <= ph_q + 1'b1;
					end
				end
				ST_HOLD: if (out_free) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// particle state: merge of lane results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				pa_q[i]  <= '0;
				om_q[i]  <= '0;
				pt_q[i]  <= '0;
			end
			quat_q[0] <= ONE;
			for (int i = 1; i < NUM_LANES; i++) quat_q[i] <= '0;
		end else if (state_q == ST_RUN && cyc_q) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				unique case (ph_q)
					PH_INNER: if (l < 3) inner_q[l] <= res[l][W-1:0];
					PH_DQ0, PH_DQ1, PH_DQ2: dq_q[l] <= res[l];
					PH_POS:   if (l < 3) pos_q[l] <= res[l][W-1:0];
					PH_VEL:   if (l < 3) begin
						vel_q[l] <= res[l][W-1:0];
						pa_q[l]  <= na_q[l];
					end
					PH_QUAT:  quat_q[l] <= res[l][W-1:0];
					PH_OMEGA: if (l < 3) begin
						om_q[l] <= res[l][W-1:0];
						pt_q[l] <= nt_q[l];
					end
					default: ;
				endcase
			end
		end
	end

	// input capture and output register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			na_q[0] <= accel_new_x;
			na_q[1] <= accel_new_y;
			na_q[2] <= accel_new_z;
			nt_q[0] <= torque_new_x;
			nt_q[1] <= torque_new_y;
			nt_q[2] <= torque_new_z;
		end
		if (state_q == ST_HOLD && out_free) begin
			for (int i = 0; i < 3; i++) begin
				out_q[i]     <= pos_q[i];
				out_q[3 + i] <= vel_q[i];
			end
			for (int i = 0; i < NUM_LANES; i++) out_q[6 + i] <= quat_q[i];
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x  = out_q[0];
	assign pos_y  = out_q[1];
	assign pos_z  = out_q[2];
	assign vel_x  = out_q[3];
	assign vel_y  = out_q[4];
	assign vel_z  = out_q[5];
	assign quat_w = out_q[6];
	assign quat_i = out_q[7];
	assign quat_j = out_q[8];
	assign quat_k = out_q[9];

endmodule

>>> rtl/rbvs_checker.sv
// ----------------------------------------------------------------------------
// rbvs_checker
// Port-level checks of the rigid body Verlet step block, bound to the top.
// ----------------------------------------------------------------------------
module rbvs_checker (
	input logic clk,
	input logic arst_n,
	input logic time_step_ready,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall
);

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// block is busy right after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while step in progress");

	// no result appears the cycle after a word is taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result too early");

	// configuration is never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		time_step_ready)
		else $error("time step write refused");

endmodule

bind rigid_body_verlet_step_top rbvs_checker u_rbvs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.time_step_ready (time_step_ready),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall)
);

>>> tb/rigid_body_verlet_step_top_tb.sv
// ----------------------------------------------------------------------------
// rigid_body_verlet_step_top_tb
// Self-checking bench for the rigid body Verlet step. A behavioral predictor
// tracks position, velocity, orientation and omega in Q8.24 with rounding and
// saturation. Every output word is compared against the oldest prediction.
// Directed extremes come first, then random accelerations and torques under
// several time steps, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module rigid_body_verlet_step_top_tb import rbvs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = 32;
	localparam int F = 24;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD = 400;

	typedef logic signed [W-1:0] word_t;
	typedef struct packed {
		word_t px, py, pz, vx, vy, vz, qw, qi, qj, qk;
	} state_word_t;

	logic clk, arst_n;
	logic time_step_valid, time_step_ready;
	logic [DT_BITS-1:0] time_step;
	logic in_valid, in_stall, out_valid, out_stall;
	word_t accel_new_x, accel_new_y, accel_new_z;
	word_t torque_new_x, torque_new_y, torque_new_z;
	word_t pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, quat_w, quat_i, quat_j, quat_k;

	rigid_body_verlet_step_top uut (.*);

	// predictor state
	longint unsigned dt_q;
	longint pos_s [3], vel_s [3], acc_s [3], tor_s [3], omg_s [3], quat_s [4];
	state_word_t expected_q [$];
	int errors;
	int idle_cycles;
	bit hold_out;

	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	function automatic longint clamp(longint v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return v;
	endfunction

	// operands are within 32 bits, so 64-bit sums never wrap
	function automatic longint sat_add(longint a, longint b);
		return clamp(a + b);
	endfunction

	// exact product, scaled down, magnitude rounded half away from zero
	function automatic longint mul_round(longint a, longint b, int sh);
		logic [127:0] m;
		logic [127:0] r;
		bit neg;
		neg = (a < 0) != (b < 0);
		m = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		r = (m + (128'd1 << (sh - 1))) >> sh;
		if (!neg) return (r > 128'(WMAX)) ? WMAX : longint'(r);
		if (r > 128'(WMAX) + 1) return WMIN;
		return -longint'(r);
	endfunction

	function automatic longint qterm(int qi, int wi, bit neg);
		longint p;
		p = mul_round(quat_s[qi], omg_s[wi], F);
		return neg ? -p : p;
	endfunction

	task automatic predict_step(input word_t a [3], input word_t t [3]);
		longint dq [4];
		longint inner;
		state_word_t e;
		for (int i = 0; i < 3; i++) begin
			inner = sat_add(vel_s[i], mul_round(acc_s[i], dt_q, F + 1));
			pos_s[i] = sat_add(pos_s[i], mul_round(inner, dt_q, F));
			vel_s[i] = sat_add(vel_s[i], mul_round(sat_add(acc_s[i], a[i]), dt_q, F + 1));
			acc_s[i] = a[i];
		end
		dq[0] = sat_add(sat_add(qterm(1, 0, 1), qterm(2, 1, 1)), qterm(3, 2, 1));
		dq[1] = sat_add(sat_add(qterm(0, 0, 0), qterm(3, 1, 0)), qterm(2, 2, 1));
		dq[2] = sat_add(sat_add(qterm(3, 0, 1), qterm(0, 1, 0)), qterm(1, 2, 0));
		dq[3] = sat_add(sat_add(qterm(2, 0, 0), qterm(1, 1, 1)), qterm(0, 2, 0));
		for (int i = 0; i < 4; i++)
			quat_s[i] = sat_add(quat_s[i], mul_round(dq[i], dt_q, F + 1));
		for (int i = 0; i < 3; i++) begin
			omg_s[i] = sat_add(omg_s[i], mul_round(sat_add(tor_s[i], t[i]), dt_q, F + 1));
			tor_s[i] = t[i];
		end
		e = '{word_t'(pos_s[0]), word_t'(pos_s[1]), word_t'(pos_s[2]),
			word_t'(vel_s[0]), word_t'(vel_s[1]), word_t'(vel_s[2]),
			word_t'(quat_s[0]), word_t'(quat_s[1]), word_t'(quat_s[2]),
			word_t'(quat_s[3])};
		expected_q.push_back(e);
	endtask

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog on accepted words
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// output stall: random gaps, or one long hold when asked
	initial begin
		int gap, held;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_out) begin
				held = 0;
				out_stall <= 1;
				while (held < LONG_HOLD) begin
					@(posedge clk);
					held++;
				end
				hold_out = 0;
				out_stall <= 0;
			end else begin
				gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
				out_stall <= (gap != 0);
				if (gap != 0) begin
					repeat (gap) @(posedge clk);
					out_stall <= 0;
				end
				while (!out_valid) @(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		state_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("unexpected output word at %0t", $realtime);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (pos_x !== e.px) report_mismatch("pos_x", pos_x, e.px);
				if (pos_y !== e.py) report_mismatch("pos_y", pos_y, e.py);
				if (pos_z !== e.pz) report_mismatch("pos_z", pos_z, e.pz);
				if (vel_x !== e.vx) report_mismatch("vel_x", vel_x, e.vx);
				if (vel_y !== e.vy) report_mismatch("vel_y", vel_y, e.vy);
				if (vel_z !== e.vz) report_mismatch("vel_z", vel_z, e.vz);
				if (quat_w !== e.qw) report_mismatch("quat_w", quat_w, e.qw);
				if (quat_i !== e.qi) report_mismatch("quat_i", quat_i, e.qi);
				if (quat_j !== e.qj) report_mismatch("quat_j", quat_j, e.qj);
				if (quat_k !== e.qk) report_mismatch("quat_k", quat_k, e.qk);
			end
		end
	end

	// send one word; gap drawn per word
	task automatic send_word(input word_t a [3], input word_t t [3], input bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : (($urandom_range(3) == 0) ? 0 : $urandom_range(6));
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		accel_new_x <= a[0]; accel_new_y <= a[1]; accel_new_z <= a[2];
		torque_new_x <= t[0]; torque_new_y <= t[1]; torque_new_z <= t[2];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_step(a, t);
	endtask

	task automatic drop_valid();
		in_valid <= 0;
		@(posedge clk);
	endtask

	// wait for all results, then settle before a register write
	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_time_step(input logic [DT_BITS-1:0] v);
		time_step_valid <= 1;
		time_step <= v;
		@(posedge clk);
		while (!time_step_ready) @(posedge clk);
		time_step_valid <= 0;
		dt_q = v;
	endtask

	function automatic word_t rand_word(input int mode);
		case (mode)
			0: return word_t'($urandom);
			1: return word_t'($signed($urandom_range(65535)) - 32768) <<< 12;
			default: return word_t'($signed($urandom_range(2047)) - 1024) <<< 14;
		endcase
	endfunction

	task automatic send_random(input int count, input int mode);
		word_t a [3], t [3];
		repeat (count) begin
			for (int i = 0; i < 3; i++) begin
				a[i] = rand_word(mode);
				t[i] = rand_word(mode);
			end
			send_word(a, t);
		end
		drop_valid();
	endtask

	// extremes of every field at reset step and at full scale, then random words at zero step
	task automatic test_directed();
		word_t a [3], t [3];
		word_t vals [6];
		vals = '{word_t'(0), word_t'(1), word_t'(-1), word_t'(WMAX), word_t'(WMIN),
			word_t'(32'h0100_0000)};
		foreach (vals[k]) begin
			a = '{vals[k], vals[(k + 1) % 6], vals[(k + 2) % 6]};
			t = '{vals[(k + 3) % 6], vals[(k + 4) % 6], vals[(k + 5) % 6]};
			send_word(a, t);
		end
		// saturation: push everything to the rails
		a = '{word_t'(WMAX), word_t'(WMIN), word_t'(WMAX)};
		t = '{word_t'(WMIN), word_t'(WMAX), word_t'(WMAX)};
		repeat (6) send_word(a, t);
		drop_valid();
		drain();
		// large step above 1.0
		write_time_step({DT_BITS{1'b1}});
		a = '{word_t'(WMIN), word_t'(WMAX), word_t'(-1)};
		t = '{word_t'(WMAX), word_t'(1), word_t'(WMIN)};
		repeat (4) send_word(a, t);
		drop_valid();
		drain();
		// zero step freezes the state
		write_time_step('0);
		send_random(4, 0);
		drain();
	endtask

	// random words over a spread of step sizes
	task automatic test_random_steps();
		logic [DT_BITS-1:0] steps [6];
		steps = '{DT_RESET, 25'd1, 25'h100_0000, 25'd1677, 25'h080_0000, 25'd16777};
		foreach (steps[k]) begin
			write_time_step(steps[k]);
			send_random(140, 2);
			send_random(60, 1);
			send_random(30, 0);
			drain();
		end
	endtask

	// receiver holds off while words keep coming, so the input backs up
	task automatic test_backpressure();
		word_t a [3], t [3];
		hold_out = 1;
		for (int n = 0; n < 30; n++) begin
			for (int i = 0; i < 3; i++) begin
				a[i] = rand_word(2);
				t[i] = rand_word(2);
			end
			send_word(a, t, 1);
		end
		drop_valid();
		drain();
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		hold_out = 0;
		arst_n = 0;
		time_step_valid = 0;
		time_step = DT_RESET;
		in_valid = 0;
		{accel_new_x, accel_new_y, accel_new_z} = '0;
		{torque_new_x, torque_new_y, torque_new_z} = '0;
		dt_q = DT_RESET;
		for (int i = 0; i < 3; i++) begin
			pos_s[i] = 0; vel_s[i] = 0; acc_s[i] = 0; tor_s[i] = 0; omg_s[i] = 0;
		end
		quat_s = '{64'sd1 << F, 0, 0, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_directed();
		test_random_steps();
		test_backpressure();
		write_time_step(DT_RESET);
		send_random(320, 2);
		drain();

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
